/* hw/rtl/bc1_bc3_block_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the block decoder checker
// Clock clk and active-low reset rst_n must be visible where these are used.
// ----------------------------------------------------------------------------
`ifndef BC1_BC3_BLOCK_DECODER_DEFINES_SVH
`define BC1_BC3_BLOCK_DECODER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bcd_pkg.sv */
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types, register indexes and constant-divide helpers of the decoder.
// ----------------------------------------------------------------------------
package bcd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int NUM_LANES  = 16;
    localparam int COORD_W    = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pix_t;

    typedef struct packed {
        logic               inb;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        pix_t               pix;
    } lane_out_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        pix_t               pix;
        logic               last;
    } pixel_t;

    // rounded 5-bit to 8-bit expansion: 8v + floor((7v + 15) / 31)
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0]  t;
        logic [16:0] p;
        t = {3'd0, v} * 8'd7 + 8'd15;
        p = {9'd0, t} * 17'd265;
        return {v, 3'd0} + {5'd0, p[15:13]};
    endfunction

    // rounded 6-bit to 8-bit expansion: 4v + floor((3v + 31) / 63)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [7:0]  t;
        logic [15:0] p;
        t = {2'd0, v} * 8'd3 + 8'd31;
        p = {8'd0, t} * 16'd261;
        return {v, 2'd0} + {6'd0, p[15:14]};
    endfunction

    // floor(s/3) for s <= 765
    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        p = {11'd0, s} * 21'd683;
        return p[18:11];
    endfunction

    // floor(s/7) for s <= 1785
    function automatic logic [7:0] div7(input logic [10:0] s);
        logic [24:0] p;
        p = {14'd0, s} * 25'd2341;
        return p[21:14];
    endfunction

    // floor(s/5) for s <= 1275
    function automatic logic [7:0] div5(input logic [10:0] s);
        logic [24:0] p;
        p = {14'd0, s} * 25'd3277;
        return p[21:14];
    endfunction

endpackage

/* hw/rtl/bcd_if.sv */
// ----------------------------------------------------------------------------
// Decoder channel interfaces
// Block input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface bcd_block_if;
    logic        valid;
    logic        ready;
    logic [11:0] block_x;
    logic [11:0] block_y;
    logic [63:0] alpha_block;
    logic [63:0] color_block;

    modport source (output valid, output block_x, output block_y,
                    output alpha_block, output color_block, input ready);
    modport sink   (input valid, input block_x, input block_y,
                    input alpha_block, input color_block, output ready);
endinterface

interface bcd_pixel_if;
    logic        valid;
    logic        ready;
    logic [13:0] pixel_x;
    logic [13:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;

    modport source (output valid, output pixel_x, output pixel_y, output red,
                    output green, output blue, output alpha, output last,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input red,
                    input green, input blue, input alpha, input last,
                    output ready);
endinterface

interface bcd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/bcd_palette.sv */
// ----------------------------------------------------------------------------
// bcd_palette
// Builds and registers the color and alpha palettes of one block.
// ----------------------------------------------------------------------------
module bcd_palette
    import bcd_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic              dxt5,
    input  logic [63:0]       color_block,
    input  logic [63:0]       alpha_block,
    output pix_t [3:0]        pal,
    output logic [7:0][7:0]   apal
);

    pix_t [3:0]      pal_reg;
    pix_t [3:0]      pal_next;
    logic [7:0][7:0] apal_reg;
    logic [7:0][7:0] apal_next;

    logic [15:0] c0;
    logic [15:0] c1;
    logic [7:0]  a0;
    logic [7:0]  a1;
    pix_t        e0;
    pix_t        e1;
    logic        four_color;

    assign c0 = color_block[15:0];
    assign c1 = color_block[31:16];
    assign a0 = alpha_block[7:0];
    assign a1 = alpha_block[15:8];

    always_comb
    begin
        e0 = '{r: expand5(c0[15:11]), g: expand6(c0[10:5]), b: expand5(c0[4:0]),
               a: 8'hFF};
        e1 = '{r: expand5(c1[15:11]), g: expand6(c1[10:5]), b: expand5(c1[4:0]),
               a: 8'hFF};
        four_color = dxt5 || (c0 > c1);

        pal_next[0] = e0;
        pal_next[1] = e1;
        if (four_color)
        begin
            pal_next[2].r = div3({1'b0, e0.r, 1'b0} + {2'b0, e1.r});
            pal_next[2].g = div3({1'b0, e0.g, 1'b0} + {2'b0, e1.g});
            pal_next[2].b = div3({1'b0, e0.b, 1'b0} + {2'b0, e1.b});
            pal_next[2].a = 8'hFF;
            pal_next[3].r = div3({2'b0, e0.r} + {1'b0, e1.r, 1'b0});
            pal_next[3].g = div3({2'b0, e0.g} + {1'b0, e1.g, 1'b0});
            pal_next[3].b = div3({2'b0, e0.b} + {1'b0, e1.b, 1'b0});
            pal_next[3].a = 8'hFF;
        end
        else
        begin
            pal_next[2].r = 8'(({1'b0, e0.r} + {1'b0, e1.r}) >> 1);
            pal_next[2].g = 8'(({1'b0, e0.g} + {1'b0, e1.g}) >> 1);
            pal_next[2].b = 8'(({1'b0, e0.b} + {1'b0, e1.b}) >> 1);
            pal_next[2].a = 8'hFF;
            pal_next[3]   = '0;
        end

        apal_next[0] = a0;
        apal_next[1] = a1;
        if (a0 > a1)
        begin
            for (int i = 1; i <= 6; i++)
            begin
                apal_next[i+1] = div7(11'(7 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1});
            end
        end
        else
        begin
            for (int i = 1; i <= 4; i++)
            begin
                apal_next[i+1] = div5(11'(5 - i) * {3'b0, a0} + 11'(i) * {3'b0, a1});
            end
            apal_next[6] = 8'd0;
            apal_next[7] = 8'd255;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pal_reg  <= pal_next;
            apal_reg <= apal_next;
        end
    end

    assign pal  = pal_reg;
    assign apal = apal_reg;

endmodule

/* hw/rtl/bcd_lane.sv */
// ----------------------------------------------------------------------------
// bcd_lane
// Decodes one pixel of the block: palette lookup, position and clip test.
// ----------------------------------------------------------------------------
module bcd_lane
    import bcd_pkg::*;
(
    input  pix_t [3:0]          pal,
    input  logic [7:0][7:0]     apal,
    input  logic                dxt5,
    input  logic [1:0]          cidx,
    input  logic [2:0]          aidx,
    input  logic [COORD_W-1:0]  base_x,
    input  logic [COORD_W-1:0]  base_y,
    input  logic [1:0]          px,
    input  logic [1:0]          py,
    input  logic [14:0]         image_width,
    input  logic [14:0]         image_height,
    output lane_out_t           result
);

    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;

    // base is a multiple of four, so the add never carries past bit 13
    assign x = base_x + {12'd0, px};
    assign y = base_y + {12'd0, py};

    always_comb
    begin
        result.x   = x;
        result.y   = y;
        result.inb = ({1'b0, x} < image_width) && ({1'b0, y} < image_height);
        result.pix = pal[cidx];
        if (dxt5)
        begin
            result.pix.a = apal[aidx];
        end
    end

endmodule

/* hw/rtl/bcd_merge.sv */
// ----------------------------------------------------------------------------
// bcd_merge
// Holds the sixteen lane results and sends the in-image ones in order.
// ----------------------------------------------------------------------------
module bcd_merge
    import bcd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  lane_out_t [NUM_LANES-1:0]   lanes,
    input  logic                        out_ready,
    output logic                        out_valid,
    output pixel_t                      out_pixel,
    output logic                        can_load
);

    lane_out_t [NUM_LANES-1:0] hold_reg;
    logic [NUM_LANES-1:0]      mask_reg;
    logic [NUM_LANES-1:0]      mask_next;
    logic [NUM_LANES-1:0]      first;
    logic [NUM_LANES-1:0]      rest;
    logic [NUM_LANES-1:0]      load_mask;
    logic [3:0]                sel;
    logic                      xfer;
    logic                      is_last;

    always_comb
    begin
        sel = '0;
        for (int i = NUM_LANES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel = 4'(i);
            end
        end
        first = mask_reg & ~(mask_reg - 1'b1);
        rest  = mask_reg & ~first;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            load_mask[i] = lanes[i].inb;
        end
    end

    assign out_valid = |mask_reg;
    assign is_last   = ~|rest;
    assign xfer      = out_valid && out_ready;
    assign can_load  = !out_valid || (xfer && is_last);

    always_comb
    begin
        out_pixel.x    = hold_reg[sel].x;
        out_pixel.y    = hold_reg[sel].y;
        out_pixel.pix  = hold_reg[sel].pix;
        out_pixel.last = is_last;
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = load_mask;
        end
        else if (xfer)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= lanes;
        end
    end

endmodule

/* hw/rtl/bc1_bc3_block_decoder.sv */
// ----------------------------------------------------------------------------
// bc1_bc3_block_decoder
// BC1/BC3 4x4 block decoder with sixteen pixel lanes and an ordered merge.
// ----------------------------------------------------------------------------
// Usage:
//   blocks : one compressed block per transfer (block coordinates, alpha and
//            color words). format selects DXT1 or DXT5 alpha handling.
//   pixels : one RGBA8 pixel per transfer in row-major order inside the block;
//            pixels outside image_width x image_height are skipped and last
//            marks the final pixel sent for the block.
//   cfg    : register writes (format, image_width, image_height), always ready;
//            write only while no block is in flight.
// First pixel: a block is registered in the palette stage on its transfer
//   and moved to the merge stage when free, which then sends its first pixel.
// Throughput: one pixel per cycle while pixels.ready stays high, set by the
//   merge stage sending pixels one at a time; a block sends as many pixels
//   as it has in-image (sixteen for an interior block), none if fully clipped.
// The palette stage takes the next block while the merge stage still sends
//   the previous one, so blocks follow without a gap.
// Reset: clears all valid state; format 0, image size 4 x 4.
// Stall: a held pixels.ready freezes the current pixel; the palette stage
//   fills and then blocks.ready drops.
// ----------------------------------------------------------------------------
module bc1_bc3_block_decoder
    import bcd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bcd_block_if.sink     blocks,
    bcd_pixel_if.source   pixels,
    bcd_cfg_if.sink       cfg
);

    logic        format_reg;
    logic [14:0] image_width_reg;
    logic [14:0] image_height_reg;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [31:0]        cidx_reg;
    logic [47:0]        aidx_reg;
    logic [COORD_W-1:0] base_x_reg;
    logic [COORD_W-1:0] base_y_reg;

    pix_t [3:0]                pal;
    logic [7:0][7:0]           apal;
    lane_out_t [NUM_LANES-1:0] lanes;
    pixel_t                    out_pixel;
    logic                      out_valid;
    logic                      can_load;
    logic                      in_xfer;
    logic                      s1_adv;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg       <= 1'b0;
            image_width_reg  <= 15'd4;
            image_height_reg <= 15'd4;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FORMAT:       format_reg       <= cfg.data[0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    // palette stage
    assign s1_adv       = s1_valid_reg && can_load;
    assign blocks.ready = !s1_valid_reg || can_load;
    assign in_xfer      = blocks.valid && blocks.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cidx_reg   <= blocks.color_block[63:32];
            aidx_reg   <= blocks.alpha_block[63:16];
            base_x_reg <= {blocks.block_x, 2'b00};
            base_y_reg <= {blocks.block_y, 2'b00};
        end
    end

    bcd_palette u_palette (
        .clk         (clk),
        .en          (in_xfer),
        .dxt5        (format_reg),
        .color_block (blocks.color_block),
        .alpha_block (blocks.alpha_block),
        .pal         (pal),
        .apal        (apal)
    );

    // one lane per pixel of the block
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        bcd_lane u_lane (
            .pal          (pal),
            .apal         (apal),
            .dxt5         (format_reg),
            .cidx         (cidx_reg[2*i +: 2]),
            .aidx         (aidx_reg[3*i +: 3]),
            .base_x       (base_x_reg),
            .base_y       (base_y_reg),
            .px           (2'(i % 4)),
            .py           (2'(i / 4)),
            .image_width  (image_width_reg),
            .image_height (image_height_reg),
            .result       (lanes[i])
        );
    end

    bcd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv),
        .lanes     (lanes),
        .out_ready (pixels.ready),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .can_load  (can_load)
    );

    assign pixels.valid   = out_valid;
    assign pixels.pixel_x = out_pixel.x;
    assign pixels.pixel_y = out_pixel.y;
    assign pixels.red     = out_pixel.pix.r;
    assign pixels.green   = out_pixel.pix.g;
    assign pixels.blue    = out_pixel.pix.b;
    assign pixels.alpha   = out_pixel.pix.a;
    assign pixels.last    = out_pixel.last;

endmodule

/* hw/rtl/bcd_checker.sv */
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level checks on the decoder's pixel stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "bc1_bc3_block_decoder_defines.svh"

module bcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [13:0] pixel_x,
    input logic [13:0] pixel_y,
    input logic [7:0]  red,
    input logic        last
);

    logic mid_xfer;

    assign mid_xfer = out_valid && out_ready && !last;

    // stalled pixel holds
    `BCD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(red) && $stable(last), "stalled pixel changed")

    // a block's remaining pixels are already decoded, so no gap inside a block
    `BCD_ASSERT_NEXT(a_no_gap, mid_xfer, out_valid, "gap inside a block")

    // next pixel of the same block lies in the same 4x4 tile
    `BCD_ASSERT_NEXT(a_same_tile, mid_xfer, pixel_x[13:2] == $past(pixel_x[13:2]) && pixel_y[13:2] == $past(pixel_y[13:2]), "pixel left its block")

    // row-major order inside the block
    `BCD_ASSERT_NEXT(a_order, mid_xfer, (pixel_y > $past(pixel_y)) || ((pixel_y == $past(pixel_y)) && (pixel_x > $past(pixel_x))), "pixel order broken")

endmodule

bind bc1_bc3_block_decoder bcd_checker u_bcd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (pixels.valid),
    .out_ready (pixels.ready),
    .pixel_x   (pixels.pixel_x),
    .pixel_y   (pixels.pixel_y),
    .red       (pixels.red),
    .last      (pixels.last)
);

/* bench/bcd_pixel_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_pixel_checker
// Watches the block, pixel and register channels of the block decoder. It
// keeps its own copy of the registers, decodes every accepted block into the
// pixels it should produce and compares each pixel transfer, field by field,
// with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module bcd_pixel_checker
    import bcd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    bcd_block_if  blocks,
    bcd_pixel_if  pixels,
    bcd_cfg_if    cfg,
    output int    errors,
    output int    pending
);

    logic        dxt5_mode;
    logic [14:0] img_w;
    logic [14:0] img_h;
    pixel_t      owed_pixels[$];
    pixel_t      want;

    // rounded widening of a 5- or 6-bit channel to 8 bits
    function automatic logic [7:0] widen(int v, int maxv);
        return 8'((v * 255 + maxv / 2) / maxv);
    endfunction

    function automatic pix_t rgb565(logic [15:0] v);
        pix_t p;
        p.r = widen(int'(v[15:11]), 31);
        p.g = widen(int'(v[10:5]), 63);
        p.b = widen(int'(v[4:0]), 31);
        p.a = 8'hFF;
        return p;
    endfunction

    function automatic pix_t mix(pix_t p0, pix_t p1, int w0, int w1, int d);
        pix_t p;
        p.r = 8'((w0 * p0.r + w1 * p1.r) / d);
        p.g = 8'((w0 * p0.g + w1 * p1.g) / d);
        p.b = 8'((w0 * p0.b + w1 * p1.b) / d);
        p.a = 8'hFF;
        return p;
    endfunction

    task automatic decode_block(logic [11:0] bx, logic [11:0] by,
                                logic [63:0] ablk, logic [63:0] cblk);
        pix_t       pal[4];
        logic [7:0] apal[8];
        pixel_t     row_major[16];
        int         a0;
        int         a1;
        int         x;
        int         y;
        int         n;
        n = 0;
        pal[0] = rgb565(cblk[15:0]);
        pal[1] = rgb565(cblk[31:16]);
        if (dxt5_mode || cblk[15:0] > cblk[31:16])
        begin
            pal[2] = mix(pal[0], pal[1], 2, 1, 3);
            pal[3] = mix(pal[0], pal[1], 1, 2, 3);
        end
        else
        begin
            // midpoint plus transparent black
            pal[2] = mix(pal[0], pal[1], 1, 1, 2);
            pal[3] = '0;
        end
        a0 = int'(ablk[7:0]);
        a1 = int'(ablk[15:8]);
        apal[0] = 8'(a0);
        apal[1] = 8'(a1);
        if (a0 > a1)
        begin
            for (int k = 1; k <= 6; k++)
                apal[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
                apal[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
            apal[6] = 8'd0;
            apal[7] = 8'd255;
        end
        for (int i = 0; i < 16; i++)
        begin
            x = 4 * bx + i % 4;
            y = 4 * by + i / 4;
            if (x >= img_w || y >= img_h)
                continue;
            row_major[n].x    = x[13:0];
            row_major[n].y    = y[13:0];
            row_major[n].pix  = pal[cblk[32 + 2 * i +: 2]];
            row_major[n].last = 1'b0;
            if (dxt5_mode)
                row_major[n].pix.a = apal[ablk[16 + 3 * i +: 3]];
            n++;
        end
        if (n > 0)
            row_major[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            owed_pixels.push_back(row_major[i]);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dxt5_mode = 1'b0;
            img_w     = 15'd4;
            img_h     = 15'd4;
            owed_pixels.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FORMAT:       dxt5_mode = cfg.data[0];
                    CFG_IMAGE_WIDTH:  img_w     = cfg.data;
                    CFG_IMAGE_HEIGHT: img_h     = cfg.data;
                    default:          ;
                endcase
            end
            if (blocks.valid && blocks.ready)
                decode_block(blocks.block_x, blocks.block_y,
                             blocks.alpha_block, blocks.color_block);
            if (pixels.valid && pixels.ready)
            begin
                if (owed_pixels.size() == 0)
                begin
                    $error("unexpected pixel transfer at (%0d,%0d)",
                           pixels.pixel_x, pixels.pixel_y);
                    errors++;
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    check_field("pixel_x", want.x, pixels.pixel_x);
                    check_field("pixel_y", want.y, pixels.pixel_y);
                    check_field("red", want.pix.r, pixels.red);
                    check_field("green", want.pix.g, pixels.green);
                    check_field("blue", want.pix.b, pixels.blue);
                    check_field("alpha", want.pix.a, pixels.alpha);
                    check_field("last", want.last, pixels.last);
                end
            end
            pending = owed_pixels.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives compressed blocks and register writes into the BC1/BC3 decoder,
// stalls the pixel output at random and with one long hold, and lets the
// checker decide whether every pixel came out right and in order.
// ----------------------------------------------------------------------------
module tb_top;
    import bcd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 8;
    localparam int NUM_PHASES       = 6;
    localparam int PHASE_BLOCKS     = 66;

    logic clk = 1'b0;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_requests;
    int   holds_done;
    int   hold_left;

    bcd_block_if blk_ch();
    bcd_pixel_if pix_ch();
    bcd_cfg_if   cfg_ch();

    bc1_bc3_block_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .blocks (blk_ch),
        .pixels (pix_ch),
        .cfg    (cfg_ch)
    );

    bcd_pixel_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .blocks  (blk_ch),
        .pixels  (pix_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #2 clk = ~clk;

    // pixel receiver: random stalls, plus a long hold on request
    initial
    begin
        holds_done   = 0;
        hold_left    = 0;
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_ch.ready <= 1'b0;
            end
            else
                pix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly blocks inside or just past the image, some anywhere
    function automatic logic [11:0] pick_coord(logic [14:0] size);
        int span;
        span = (size + 3) / 4;
        if (span > 4095 || $urandom_range(7) == 0)
            return 12'($urandom);
        return 12'($urandom_range(span));
    endfunction

    function automatic logic [14:0] pick_size();
        case ($urandom_range(5))
            0:       return 15'd16384;
            1:       return 15'd32767;
            2:       return 15'($urandom_range(16384, 1));
            default: return 15'($urandom_range(64, 1));
        endcase
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_config(logic fmt, logic [14:0] w, logic [14:0] h);
        write_reg(CFG_FORMAT, {14'd0, fmt});
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
    endtask

    task automatic send_block(logic [11:0] bx, logic [11:0] by,
                              logic [63:0] ablk, logic [63:0] cblk);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            blk_ch.valid <= 1'b0;
            @(negedge clk);
        end
        blk_ch.valid       <= 1'b1;
        blk_ch.block_x     <= bx;
        blk_ch.block_y     <= by;
        blk_ch.alpha_block <= ablk;
        blk_ch.color_block <= cblk;
        do @(posedge clk); while (!blk_ch.ready);
    endtask

    // drop valid, wait for every owed pixel, then let a clipped block drain
    task automatic settle();
        @(negedge clk);
        blk_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [63:0] noise;
        logic        fmt;
        logic [14:0] w;
        logic [14:0] h;

        rst_n              = 1'b0;
        blk_ch.valid       = 1'b0;
        blk_ch.block_x     = '0;
        blk_ch.block_y     = '0;
        blk_ch.alpha_block = '0;
        blk_ch.color_block = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        hold_requests      = 0;
        send_idle_pct      = 9;
        recv_idle_pct      = 55;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // DXT1, 4x4 image from reset
        noise = rand64();
        send_block(12'd0, 12'd0, 64'd0, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
        send_block(12'd0, 12'd0, 64'd0, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        send_block(12'd0, 12'd0, noise, {32'h1B1B1B1B, 16'h8410, 16'h8410});
        send_block(12'd0, 12'd0, 64'd0, {64{1'b1}});
        send_block(12'd0, 12'd0, {64{1'b1}}, 64'd0);
        send_block(12'd0, 12'd0, {64{1'b1}}, rand64());
        send_block(12'd1, 12'd0, rand64(), rand64());
        send_block(12'd4095, 12'd4095, rand64(), rand64());
        send_block(12'd0, 12'd1, rand64(), rand64());
        settle();

        // spare index is ignored, format keeps bit 0 only
        write_reg(CFG_SPARE, 15'h7FFF);
        write_reg(CFG_FORMAT, 15'h7FFE);
        set_config(1'b1, 15'd32767, 15'd32767);
        noise = rand64();
        send_block(12'd0, 12'd0, {48'hFAC688_FAC688, 8'd10, 8'd200}, noise);
        send_block(12'd0, 12'd0, {48'hFAC688_FAC688, 8'd200, 8'd10}, noise);
        send_block(12'd0, 12'd0, {48'hFAC688_FAC688, 8'd77, 8'd77}, rand64());
        send_block(12'd0, 12'd0, {64{1'b1}}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
        send_block(12'd0, 12'd0, 64'd0, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
        send_block(12'd4095, 12'd4095, rand64(), rand64());
        send_block(12'd4095, 12'd0, rand64(), rand64());
        send_block(12'd0, 12'd4095, rand64(), rand64());
        settle();

        // zero size clips everything
        set_config(1'b0, 15'd0, 15'd5);
        send_block(12'd0, 12'd0, rand64(), rand64());
        settle();
        set_config(1'b0, 15'd5, 15'd0);
        send_block(12'd0, 12'd0, rand64(), rand64());
        settle();

        // partial blocks on the right and bottom edges, plus whole and fully clipped ones
        set_config(1'b0, 15'd6, 15'd7);
        send_block(12'd1, 12'd1, rand64(), rand64());
        send_block(12'd0, 12'd0, rand64(), rand64());
        send_block(12'd1, 12'd0, rand64(), rand64());
        settle();
        set_config(1'b0, 15'd1, 15'd1);
        send_block(12'd0, 12'd0, rand64(), rand64());
        send_block(12'd0, 12'd1, rand64(), rand64());
        settle();
        set_config(1'b1, 15'd16384, 15'd16384);
        send_block(12'd4095, 12'd4095, rand64(), rand64());

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            if (phase == 2)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 9;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            fmt = $urandom_range(1);
            if (phase % 3 == 0)
            begin
                w = (phase == 0) ? 15'd16384 : 15'd32767;
                h = w;
            end
            else
            begin
                w = pick_size();
                h = pick_size();
            end
            set_config(fmt, w, h);
            // in phase 1, fill the decoder up behind a long output hold
            if (phase == 1)
                hold_requests++;
            for (int n = 0; n < PHASE_BLOCKS; n++)
            begin
                if (phase == 4 && n == PHASE_BLOCKS / 2)
                    settle();
                send_block(pick_coord(w), pick_coord(h), rand64(), rand64());
            end
        end
        settle();

        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* bc1_bc3_block_decoder.f */
+incdir+hw/rtl
hw/rtl/bcd_pkg.sv
hw/rtl/bcd_if.sv
hw/rtl/bcd_palette.sv
hw/rtl/bcd_lane.sv
hw/rtl/bcd_merge.sv
hw/rtl/bc1_bc3_block_decoder.sv
hw/rtl/bcd_checker.sv
bench/bcd_pixel_checker.sv
bench/tb_top.sv
